>>> rtl/ssbe_pkg.sv
// Package for the stereo surround and bass effect chain.
// Holds the controller state type, command and status structs and register indexes.
// No dependencies.
`default_nettype none
package ssbe_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegEnables = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDelayLen = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHighpass = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLowpass = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBass = 3'd4;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StRead,
    StHp,
    StLp,
    StDc,
    StBass,
    StSmooth,
    StOut
  } state_e;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic do_read;
    logic do_hp;
    logic do_lp;
    logic do_dc;
    logic do_bass;
    logic do_smooth;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/stereo_surround_bass_effect_chain.sv
// Top level of the stereo surround and bass effect chain.
// Depends on ssbe_pkg, ssbe_ctrl and ssbe_datapath.
//
// Channel   Direction  Signals
// in        slave      in_valid_i, in_ready_o, left_in_i, right_in_i, block_last_i
// out       master     out_valid_o, out_ready_i, left_out_o, right_out_o, block_last_out_o
// config    slave      cfg_we_i, cfg_index_i, cfg_data_i
//
// The controller walks one filter section per cycle; with surround off it
// skips the read, high-pass and low-pass states.
// After reset the delay memory is cleared, one entry a cycle, before the
// first beat is accepted.
// A finished beat waits in the output register; the next beat is accepted
// as soon as that register is empty or being read.
`default_nettype none
module stereo_surround_bass_effect_chain
  import ssbe_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH = 2048,
  parameter int unsigned COEF_WIDTH  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [27:0] left_in_i,
  input  wire logic signed [27:0] right_in_i,
  input  wire logic               block_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      left_out_o,
  output logic signed [31:0]      right_out_o,
  output logic                    block_last_out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [47:0]        cfg_data_i
);

  logic [2:0]  en_q;
  logic [11:0] len_q;
  logic [47:0] hp_q, lp_q, bass_q;
  cmd_t    cmd;
  status_t status;

  // Host register file; the host must write only while the block is idle, as the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0; len_q <= 12'd960; hp_q <= '0; lp_q <= '0; bass_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegEnables:  en_q <= cfg_data_i[2:0];
        RegDelayLen: len_q <= cfg_data_i[11:0];
        RegHighpass: hp_q <= cfg_data_i;
        RegLowpass:  lp_q <= cfg_data_i;
        RegBass:     bass_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  ssbe_ctrl u_ctrl (
    .clk_i, .rst_ni, .enables_i(en_q), .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i, .status_i(status), .cmd_o(cmd)
  );

  ssbe_datapath #(.DELAY_DEPTH(DELAY_DEPTH), .COEF_WIDTH(COEF_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .delay_len_i(len_q),
    .hp_coefs_i(hp_q), .lp_coefs_i(lp_q), .bass_coefs_i(bass_q),
    .left_i(left_in_i), .right_i(right_in_i), .last_i(block_last_i),
    .left_o(left_out_o), .right_o(right_out_o), .last_o(block_last_out_o)
  );

  // A waiting result must not change while it is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(left_out_o) && $stable(right_out_o))
    else $error("stalled result changed");

  // Input is never taken while a command sequence is under way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_read |-> !in_ready_o)
    else $error("input accepted mid sequence");

  // Only one datapath step runs in a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.do_read, cmd.do_hp, cmd.do_lp, cmd.clear_step}))
    else $error("overlapping commands");

endmodule
`default_nettype wire

>>> rtl/ssbe_ctrl.sv
// Controller state machine of the effect chain.
// Depends on ssbe_pkg for the state type and the command struct.
`default_nettype none
module ssbe_ctrl
  import ssbe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [2:0] enables_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire status_t    status_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A frame is taken when the datapath is free and the output slot is
  // empty or being emptied in the same cycle.
  logic take;
  assign take = (state_q == StIdle) && in_valid_i && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:  if (status_i.clear_done) state_d = StIdle;
      StIdle:   if (take) state_d = enables_i[0] ? StRead : StDc;
      StRead:   state_d = StHp;
      StHp:     state_d = StLp;
      StLp:     state_d = StDc;
      StDc:     state_d = StBass;
      StBass:   state_d = StSmooth;
      StSmooth: state_d = StOut;
      StOut:    state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (state_q == StOut) out_valid_d = 1'b1;
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StClear:  cmd_o.clear_step = 1'b1;
      StIdle:   cmd_o.load = take;
      StRead:   cmd_o.do_read = 1'b1;
      StHp:     cmd_o.do_hp = 1'b1;
      StLp:     cmd_o.do_lp = 1'b1;
      StDc:     cmd_o.do_dc = enables_i[1];
      StBass:   cmd_o.do_bass = enables_i[1];
      StSmooth: cmd_o.do_smooth = enables_i[2];
      StOut:    cmd_o = '0;
      default:  cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/ssbe_datapath.sv
// Datapath of the effect chain: delay memory, filter state and arithmetic.
// Depends on ssbe_pkg for the command and status structs.
`default_nettype none
module ssbe_datapath
  import ssbe_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH = 2048,
  parameter int unsigned COEF_WIDTH  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  input  wire logic [11:0]        delay_len_i,
  input  wire logic [47:0]        hp_coefs_i,
  input  wire logic [47:0]        lp_coefs_i,
  input  wire logic [47:0]        bass_coefs_i,
  input  wire logic signed [27:0] left_i,
  input  wire logic signed [27:0] right_i,
  input  wire logic               last_i,
  output logic signed [31:0]      left_o,
  output logic signed [31:0]      right_o,
  output logic                    last_o
);

  localparam int unsigned AddrW = $clog2(DELAY_DEPTH);

  logic [23:0] mem [DELAY_DEPTH];
  logic [AddrW-1:0] pos_q, clr_q;
  logic signed [31:0] l_q, r_q, echo_q, v0_q;
  logic signed [31:0] hp_in_q, hp_out_q, lp_out_q, bass_in_q, bass_out_q;
  logic signed [31:0] dcin_l_q, dcin_r_q, dcout_l_q, dcout_r_q, sm_l_q, sm_r_q;
  logic last_q, done_q;
  logic [23:0] rd_q;

  function automatic logic signed [31:0] cf(input logic [47:0] reg_v, input int k);
    logic [63:0] w;
    logic [COEF_WIDTH-1:0] c;
    w = {16'd0, reg_v} >> (k * COEF_WIDTH);
    c = w[COEF_WIDTH-1:0];
    return 32'(signed'(c));
  endfunction

  // One section per step; each product is a 32 by COEF_WIDTH multiply.
  function automatic logic signed [31:0] sect(input logic [47:0] reg_v,
      input logic signed [31:0] x, input logic signed [31:0] x1,
      input logic signed [31:0] y1);
    logic signed [31:0] acc;
    acc = cf(reg_v, 0) * x + cf(reg_v, 1) * x1 + cf(reg_v, 2) * y1;
    return acc;
  endfunction

  logic signed [31:0] lp_acc, lp_v, bass_acc, bass_y, xm;
  logic signed [31:0] dl, dr, yl, yr, ln, rn, hl, hr;
  logic [31:0] mid;
  logic [AddrW:0] pos_inc, len_eff;

  always_comb begin
    mid    = 32'(l_q + r_q + 32'sd256);
    lp_acc = sect(lp_coefs_i, v0_q, hp_out_q, lp_out_q);
    lp_v   = lp_acc >>> 2;
    dl = dcin_l_q - l_q;
    dr = dcin_r_q - r_q;
    yl = (dl >>> 10) - dl + dcout_l_q;
    yr = (dr >>> 10) - dr + dcout_r_q;
    xm = (l_q + r_q + 32'sd256) >>> 9;
    bass_acc = sect(bass_coefs_i, xm, bass_in_q, bass_out_q);
    bass_y = bass_acc >>> 2;
    ln = l_q + bass_y;
    rn = r_q + bass_y;
    hl = l_q >>> 1;
    hr = r_q >>> 1;
    pos_inc = {1'b0, pos_q} + 1'b1;
    len_eff = (32'(delay_len_i) > DELAY_DEPTH) ? (AddrW+1)'(DELAY_DEPTH)
                                               : (AddrW+1)'(delay_len_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) mem[clr_q] <= '0;
    else if (cmd_i.do_read) mem[pos_q] <= 24'(signed'(mid) >>> 9);
    rd_q <= mem[pos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; done_q <= 1'b0; pos_q <= '0;
      hp_in_q <= '0; hp_out_q <= '0; lp_out_q <= '0;
      bass_in_q <= '0; bass_out_q <= '0;
      dcin_l_q <= '0; dcin_r_q <= '0; dcout_l_q <= '0; dcout_r_q <= '0;
      sm_l_q <= '0; sm_r_q <= '0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q  <= clr_q + 1'b1;
        done_q <= (clr_q == AddrW'(DELAY_DEPTH - 1));
      end
      if (cmd_i.do_read) pos_q <= (pos_inc >= len_eff) ? '0 : pos_inc[AddrW-1:0];
      if (cmd_i.do_lp) begin
        hp_in_q <= echo_q;
        hp_out_q <= v0_q;
        lp_out_q <= lp_v >>> 8;
      end
      if (cmd_i.do_dc) begin
        dcin_l_q <= l_q; dcin_r_q <= r_q;
        dcout_l_q <= yl - (yl >>> 9);
        dcout_r_q <= yr - (yr >>> 9);
      end
      if (cmd_i.do_bass) begin
        bass_in_q <= xm;
        bass_out_q <= (bass_y + 32'sd128) >>> 8;
      end
      if (cmd_i.do_smooth) begin
        sm_l_q <= hl; sm_r_q <= hr;
      end
    end
  end

  // Payload registers. The read stage fetches the echo, the high-pass and
  // low-pass steps run the surround sections, then DC removal, bass and smoothing follow.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      l_q <= 32'(left_i); r_q <= 32'(right_i); last_q <= last_i;
    end
    if (cmd_i.do_hp) echo_q <= 32'(signed'(rd_q));
    if (cmd_i.do_lp) begin
      l_q <= l_q + lp_v; r_q <= r_q - lp_v;
    end
    if (cmd_i.do_hp) v0_q <= sect(hp_coefs_i, 32'(signed'(rd_q)), hp_in_q, hp_out_q) >>> 10;
    if (cmd_i.do_dc) begin
      l_q <= yl; r_q <= yr;
    end
    if (cmd_i.do_bass) begin
      l_q <= ln; r_q <= rn;
    end
    if (cmd_i.do_smooth) begin
      l_q <= hl + sm_l_q; r_q <= hr + sm_r_q;
    end
  end

  assign status_o.clear_done = done_q;
  assign left_o  = l_q;
  assign right_o = r_q;
  assign last_o  = last_q;

endmodule
`default_nettype wire

>>> dv/ssbe_checker.sv
// Checker for the stereo surround and bass effect chain.
// Mirrors the register writes, predicts each output frame and compares it.
// Depends on ssbe_pkg.
`default_nettype none
module ssbe_checker
  import ssbe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic signed [27:0] left_in_i,
  input  wire logic signed [27:0] right_in_i,
  input  wire logic               block_last_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [31:0] left_out_i,
  input  wire logic signed [31:0] right_out_i,
  input  wire logic               block_last_out_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [47:0]        cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic               last;
  } frame_t;

  frame_t frames_due[$];

  logic [2:0]         enables;
  logic [11:0]        delay_len;
  logic [47:0]        hp_coefs, lp_coefs, bass_coefs;
  logic [23:0]        echo_line [2048];
  logic [31:0]        echo_pos;
  logic signed [31:0] hp_x1, hp_y1, lp_y1, bass_x1, bass_y1;
  logic signed [31:0] dc_x1 [2];
  logic signed [31:0] dc_y1 [2];
  logic signed [31:0] half_prev [2];

  assign pending_o = frames_due.size();

  function automatic logic signed [31:0] filter_section(logic [47:0] c,
      logic signed [31:0] x, logic signed [31:0] x1, logic signed [31:0] y1, int sh);
    logic signed [31:0] acc;
    acc = 32'(signed'(c[15:0])) * x + 32'(signed'(c[31:16])) * x1
        + 32'(signed'(c[47:32])) * y1;
    return acc >>> sh;
  endfunction

  function automatic logic signed [31:0] dc_block(int ch, logic signed [31:0] x);
    logic signed [31:0] d, y;
    d = dc_x1[ch] - x;
    y = (d >>> 10) - d + dc_y1[ch];
    dc_x1[ch] = x;
    dc_y1[ch] = y - (y >>> 9);
    return y;
  endfunction

  function automatic frame_t process_frame(logic signed [27:0] li,
      logic signed [27:0] ri, logic last);
    logic signed [31:0] l, r, echo, hp, v, xm, y, hl, hr;
    logic [31:0] lim, pos;
    frame_t f;
    l = 32'(li);
    r = 32'(ri);
    if (enables[0]) begin
      lim = (delay_len > 2048) ? 2048 : delay_len;
      pos = echo_pos % 2048;
      echo = 32'(signed'(echo_line[pos]));
      echo_line[pos] = 24'((l + r + 256) >>> 9);
      hp = filter_section(hp_coefs, echo, hp_x1, hp_y1, 10);
      hp_x1 = echo;
      v = filter_section(lp_coefs, hp, hp_y1, lp_y1, 2);
      hp_y1 = hp;
      lp_y1 = v >>> 8;
      l = l + v;
      r = r - v;
      pos++;
      echo_pos = (pos >= lim) ? 0 : pos;
    end
    if (enables[1]) begin
      l = dc_block(0, l);
      r = dc_block(1, r);
      xm = (l + r + 32'sh100) >>> 9;
      y = filter_section(bass_coefs, xm, bass_x1, bass_y1, 2);
      bass_x1 = xm;
      l = l + y;
      r = r + y;
      bass_y1 = (y + 32'sh80) >>> 8;
    end
    if (enables[2]) begin
      hl = l >>> 1;
      hr = r >>> 1;
      l = hl + half_prev[0];
      r = hr + half_prev[1];
      half_prev[0] = hl;
      half_prev[1] = hr;
    end
    f.left = l;
    f.right = r;
    f.last = last;
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t got, want;
    if (!rst_ni) begin
      enables = '0;
      delay_len = 12'd960;
      hp_coefs = '0;
      lp_coefs = '0;
      bass_coefs = '0;
      foreach (echo_line[i]) echo_line[i] = '0;
      echo_pos = 0;
      {hp_x1, hp_y1, lp_y1, bass_x1, bass_y1} = '0;
      dc_x1 = '{0, 0};
      dc_y1 = '{0, 0};
      half_prev = '{0, 0};
      frames_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegEnables:  enables = cfg_data_i[2:0];
          RegDelayLen: delay_len = cfg_data_i[11:0];
          RegHighpass: hp_coefs = cfg_data_i;
          RegLowpass:  lp_coefs = cfg_data_i;
          RegBass:     bass_coefs = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        frames_due.push_back(process_frame(left_in_i, right_in_i, block_last_i));
      if (out_valid_i && out_ready_i) begin
        got = '{left_out_i, right_out_i, block_last_out_i};
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected output beat, actual %0d %0d %0b", $time,
                   got.left, got.right, got.last);
          fail_count_o++;
        end else begin
          want = frames_due.pop_front();
          if (got.left !== want.left) begin
            $display("%0t: left expected %0d actual %0d", $time, want.left, got.left);
            fail_count_o++;
          end
          if (got.right !== want.right) begin
            $display("%0t: right expected %0d actual %0d", $time, want.right, got.right);
            fail_count_o++;
          end
          if (got.last !== want.last) begin
            $display("%0t: block end expected %0b actual %0b", $time, want.last,
                     got.last);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Top of the testbench for the stereo surround and bass effect chain.
// Drives frames and register writes, and gives the verdict from ssbe_checker.
// Depends on ssbe_pkg, ssbe_checker and the block itself.
`default_nettype none
module testbench;
  import ssbe_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [27:0] left_in_i = '0;
  logic signed [27:0] right_in_i = '0;
  logic               block_last_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] left_out_o, right_out_o;
  logic               block_last_out_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [47:0]        cfg_data_i = '0;
  int                 fail_count, pending;

  // Percentages of cycles in which the sender and the receiver hold back.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  always #6 clk_i = ~clk_i;

  stereo_surround_bass_effect_chain dut (.*);

  ssbe_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .left_in_i, .right_in_i,
    .block_last_i, .out_valid_i(out_valid_o), .out_ready_i, .left_out_i(left_out_o),
    .right_out_i(right_out_o), .block_last_out_i(block_last_out_o), .cfg_we_i,
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls at random, at the rate set for the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Writes one register during a single cycle; only called while idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [47:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one frame and holds it until the block takes it. Valid is left
  // high after the accepting edge, so that a following frame can go straight
  // on; a gap or drain() lowers it.
  task automatic send_frame(logic signed [27:0] l, logic signed [27:0] r, logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_in_i <= l;
    right_in_i <= r;
    block_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Waits until every predicted frame has come out, plus a margin so that the
  // block has surely gone idle before the next register write.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Small coefficients keep the filters mostly stable, so that the state
  // carries meaningful values rather than wrapping noise every frame.
  function automatic logic [15:0] soft_coef();
    return 16'($signed($urandom_range(2047)) - 1024);
  endfunction

  function automatic logic [47:0] rand_coefs();
    if ($urandom_range(9) == 0) return 48'({$urandom, $urandom});
    return {soft_coef(), soft_coef(), soft_coef()};
  endfunction

  function automatic logic signed [27:0] rand_sample();
    case ($urandom_range(5))
      0:       return 28'sh7FFFFFF;
      1:       return -28'sh8000000;
      2:       return 28'($signed($urandom_range(2000)) - 1000);
      default: return 28'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    int len_pick;
    write_reg(RegEnables, 48'($urandom_range(7)));
    len_pick = $urandom_range(5);
    write_reg(RegDelayLen, len_pick == 0 ? 48'd1 : len_pick == 1 ? 48'd2048 :
              len_pick == 2 ? 48'd4095 : len_pick == 3 ? 48'd0 :
              48'($urandom_range(1, 40)));
    write_reg(RegHighpass, rand_coefs());
    write_reg(RegLowpass, rand_coefs());
    write_reg(RegBass, rand_coefs());
    // An index past the last register must be ignored.
    if ($urandom_range(3) == 0)
      write_reg(CfgIdxW'(5 + $urandom_range(2)), 48'({$urandom, $urandom}));
    for (int i = 0; i < count; i++)
      send_frame(rand_sample(), rand_sample(), $urandom_range(7) == 0);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: everything off first, then every stage alone and all
    // together, with the field extremes and the delay length at both ends.
    send_frame(28'sh7FFFFFF, -28'sh8000000, 1'b1);
    drain();
    write_reg(RegHighpass, {16'h7FFF, 16'h8000, 16'h0400});
    write_reg(RegLowpass, {16'h8000, 16'h7FFF, 16'h0200});
    write_reg(RegBass, {16'hFC00, 16'h0300, 16'h0400});
    write_reg(RegDelayLen, 48'd1);
    for (int e = 1; e < 8; e++) begin
      write_reg(RegEnables, 48'(e));
      send_frame(28'sh7FFFFFF, 28'sh7FFFFFF, 1'b0);
      send_frame(-28'sh8000000, -28'sh8000000, 1'b1);
      send_frame(28'sh0, -28'sh1, 1'b0);
      drain();
    end
    // Length zero keeps the position at zero; above the store size it clamps; a
    // shortened length wraps a position already past it.
    write_reg(RegDelayLen, 48'd0);
    send_frame(28'sh1234567, 28'sh7654321, 1'b0);
    drain();
    write_reg(RegDelayLen, 48'd4095);
    send_frame(28'sh0ABCDEF, -28'sh0FEDCBA, 1'b1);
    send_frame(28'sh5555555, 28'sh2AAAAAA, 1'b0);
    drain();
    write_reg(RegDelayLen, 48'd1);
    send_frame(28'sh0000100, 28'sh0000200, 1'b0);
    drain();

    // Random part in three idling regimes, several settings in each.
    send_gap_pct = 27;
    recv_stall_pct = 48;
    repeat (4) random_phase(80);
    send_gap_pct = 48;
    recv_stall_pct = 27;
    repeat (4) random_phase(80);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    repeat (5) random_phase(80);

    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog: well beyond the slowest correct run, clearing pass included.
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
